// ----- design/isws_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the IMU scaling and window statistics core.
// No dependencies.
package isws_pkg;

    localparam int RAW_W       = 16;
    localparam int SCALE_W     = 17;
    localparam int MAG_W       = 16;
    localparam int WIDE_W      = 32;
    localparam int MUL_W       = 18;
    localparam int ROOT_REM_W  = 18;
    localparam int CNT_W       = 4;
    localparam int SQ_CYCLES   = 3;
    localparam int ROOT_CYCLES = 8;
    localparam int DIV_CYCLES  = 16;
    localparam int OLD_SQ_SLOT = 6;

    // 80336 / 65536 turns 8192 counts per g into 1/1024 m/s^2,
    // 128072 / 65536 turns 65.5 counts per deg/s into 1/128 deg/s
    localparam logic signed [MUL_W-1:0] ACCEL_MUL = 18'sd80336;
    localparam logic signed [MUL_W-1:0] RATE_MUL  = 18'sd128072;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ESQ,
        ST_ROOT1,
        ST_MAGSQ,
        ST_UPD,
        ST_DIV,
        ST_MEANSQ,
        ST_VAR,
        ST_ROOT2,
        ST_DONE
    } isws_state_t;

    typedef struct packed {
        logic [ROOT_REM_W-1:0] rem;
        logic [MAG_W-1:0]      root;
    } root_acc_t;

    // One digit of the integer square root: bring down two radicand bits,
    // try root*4+1, keep one result bit.
    function automatic root_acc_t root_step(root_acc_t acc, logic [1:0] pair);
        logic [ROOT_REM_W-1:0] rem_sh;
        logic [ROOT_REM_W-1:0] trial;
        root_acc_t             res;
        rem_sh = {acc.rem[ROOT_REM_W-3:0], pair};
        trial  = {acc.root, 2'b01};
        if (rem_sh >= trial) begin
            res.rem  = rem_sh - trial;
            res.root = {acc.root[MAG_W-2:0], 1'b1};
        end else begin
            res.rem  = rem_sh;
            res.root = {acc.root[MAG_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

// ----- design/imu_scale_and_window_stats_core.sv -----
`timescale 1ns / 1ps
// IMU six-axis scaling with sliding-window magnitude mean and deviation.
// Depends on isws_pkg and isws_ram.
//
//   channel | direction | handshake          | word
//   s_      | in        | s_valid / s_ready  | six raw 16-bit signed axis counts
//   m_      | out       | m_valid / m_ready  | six scaled axes, window mean and std
//
// One word is worked through before the next is accepted: three squares on the shared
// multiplier, two square roots at two result bits a cycle, and a divide by WINDOW_LEN
// at two quotient bits a cycle.
// After reset a clearing pass writes zero to all WINDOW_LEN ring entries, one per
// cycle; s_ready stays low until that pass is done.
// The result sits in an output register, so a stalled m_ready holds the next word
// only in its final state, ST_DONE, until the register frees.
module imu_scale_and_window_stats_core #(
    parameter int WINDOW_LEN = 64
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_valid,
    output logic                                        s_ready,
    input  logic signed [isws_pkg::RAW_W-1:0]           s_raw_accel_x,
    input  logic signed [isws_pkg::RAW_W-1:0]           s_raw_accel_y,
    input  logic signed [isws_pkg::RAW_W-1:0]           s_raw_accel_z,
    input  logic signed [isws_pkg::RAW_W-1:0]           s_raw_rate_x,
    input  logic signed [isws_pkg::RAW_W-1:0]           s_raw_rate_y,
    input  logic signed [isws_pkg::RAW_W-1:0]           s_raw_rate_z,
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic signed [isws_pkg::SCALE_W-1:0]         m_accel_x_out,
    output logic signed [isws_pkg::SCALE_W-1:0]         m_accel_y_out,
    output logic signed [isws_pkg::SCALE_W-1:0]         m_accel_z_out,
    output logic signed [isws_pkg::SCALE_W-1:0]         m_rate_x_out,
    output logic signed [isws_pkg::SCALE_W-1:0]         m_rate_y_out,
    output logic signed [isws_pkg::SCALE_W-1:0]         m_rate_z_out,
    output logic        [isws_pkg::MAG_W-1:0]           m_window_mean,
    output logic        [isws_pkg::MAG_W-1:0]           m_window_std
);

    import isws_pkg::*;

    localparam int SLOT_W  = $clog2(WINDOW_LEN);
    localparam int SUM_W   = MAG_W + SLOT_W;
    localparam int SQSUM_W = 2 * MAG_W + SLOT_W;
    localparam int REM_W   = SLOT_W + 1;
    localparam logic [REM_W-1:0]  DIVISOR   = REM_W'(WINDOW_LEN);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);

    isws_state_t state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SQSUM_W-1:0] sqsum_reg, sqsum_next;

    logic signed [RAW_W-1:0]   raw_acc_reg [3];
    logic signed [RAW_W-1:0]   raw_acc_next [3];
    logic signed [RAW_W-1:0]   raw_rate_reg [3];
    logic signed [RAW_W-1:0]   raw_rate_next [3];
    logic signed [SCALE_W-1:0] acc_sc_reg [3];
    logic signed [SCALE_W-1:0] acc_sc_next [3];
    logic signed [SCALE_W-1:0] rate_sc_reg [3];
    logic signed [SCALE_W-1:0] rate_sc_next [3];

    logic [WIDE_W-1:0] energy_reg, energy_next;
    logic [WIDE_W-1:0] old_sq_reg, old_sq_next;
    logic [WIDE_W-1:0] mag_sq_reg, mag_sq_next;
    logic [WIDE_W-1:0] mean_sq_reg, mean_sq_next;
    logic [WIDE_W-1:0] variance;

    logic [WIDE_W-1:0] rt_x_reg, rt_x_next;
    root_acc_t         rt_reg, rt_next, rt_mid, rt_step;

    logic [REM_W-1:0]  dvs_rem_reg, dvs_rem_next, dvs_rem_step;
    logic [WIDE_W-1:0] dvs_q_reg, dvs_q_next, dvs_q_step;
    logic [REM_W-1:0]  dvq_rem_reg, dvq_rem_next, dvq_rem_step;
    logic [WIDE_W-1:0] dvq_q_reg, dvq_q_next, dvq_q_step;
    logic [REM_W-1:0]  rem_sh;

    logic signed [SCALE_W-1:0] m_acc_reg [3];
    logic signed [SCALE_W-1:0] m_acc_next [3];
    logic signed [SCALE_W-1:0] m_rate_reg [3];
    logic signed [SCALE_W-1:0] m_rate_next [3];
    logic [MAG_W-1:0] m_mean_reg, m_mean_next;
    logic [MAG_W-1:0] m_std_reg, m_std_next;
    logic             m_valid_reg, m_valid_next;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [MAG_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [MAG_W-1:0]  ram_rdata;
    logic              s_accept;

    isws_ram #(
        .WIDTH(MAG_W),
        .DEPTH(WINDOW_LEN)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign ram_re   = s_accept;

    // shared multiplier: axis squares, axis scaling, ring-entry, magnitude and mean squares
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_ESQ: begin
                case (cnt_reg)
                    CNT_W'(0): mul_a = MUL_W'(raw_acc_reg[0]);
                    CNT_W'(1): mul_a = MUL_W'(raw_acc_reg[1]);
                    default:   mul_a = MUL_W'(raw_acc_reg[2]);
                endcase
                mul_b = mul_a;
            end
            ST_ROOT1: begin
                case (cnt_reg)
                    CNT_W'(0): begin mul_a = MUL_W'(raw_acc_reg[0]);  mul_b = ACCEL_MUL; end
                    CNT_W'(1): begin mul_a = MUL_W'(raw_acc_reg[1]);  mul_b = ACCEL_MUL; end
                    CNT_W'(2): begin mul_a = MUL_W'(raw_acc_reg[2]);  mul_b = ACCEL_MUL; end
                    CNT_W'(3): begin mul_a = MUL_W'(raw_rate_reg[0]); mul_b = RATE_MUL;  end
                    CNT_W'(4): begin mul_a = MUL_W'(raw_rate_reg[1]); mul_b = RATE_MUL;  end
                    CNT_W'(5): begin mul_a = MUL_W'(raw_rate_reg[2]); mul_b = RATE_MUL;  end
                    default: begin
                        mul_a = signed'({2'b00, ram_rdata});
                        mul_b = mul_a;
                    end
                endcase
            end
            ST_MAGSQ: begin
                mul_a = signed'({2'b00, rt_reg.root});
                mul_b = mul_a;
            end
            ST_MEANSQ: begin
                mul_a = signed'({2'b00, dvs_q_reg[MAG_W-1:0]});
                mul_b = mul_a;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // two root digits per cycle
    always_comb begin
        rt_mid  = root_step(rt_reg, rt_x_reg[WIDE_W-1 -: 2]);
        rt_step = root_step(rt_mid, rt_x_reg[WIDE_W-3 -: 2]);
    end

    // two restoring-divide steps per cycle on each of the two dividers
    always_comb begin
        dvs_rem_step = dvs_rem_reg;
        dvs_q_step   = dvs_q_reg;
        dvq_rem_step = dvq_rem_reg;
        dvq_q_step   = dvq_q_reg;
        rem_sh       = '0;
        for (int i = 0; i < 2; i++) begin
            rem_sh     = {dvs_rem_step[REM_W-2:0], dvs_q_step[WIDE_W-1]};
            dvs_q_step = {dvs_q_step[WIDE_W-2:0], 1'b0};
            if (rem_sh >= DIVISOR) begin
                dvs_rem_step  = rem_sh - DIVISOR;
                dvs_q_step[0] = 1'b1;
            end else begin
                dvs_rem_step = rem_sh;
            end
            rem_sh     = {dvq_rem_step[REM_W-2:0], dvq_q_step[WIDE_W-1]};
            dvq_q_step = {dvq_q_step[WIDE_W-2:0], 1'b0};
            if (rem_sh >= DIVISOR) begin
                dvq_rem_step  = rem_sh - DIVISOR;
                dvq_q_step[0] = 1'b1;
            end else begin
                dvq_rem_step = rem_sh;
            end
        end
    end

    assign variance = (dvq_q_reg > mean_sq_reg) ? (dvq_q_reg - mean_sq_reg) : '0;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        slot_next     = slot_reg;
        sum_next      = sum_reg;
        sqsum_next    = sqsum_reg;
        raw_acc_next  = raw_acc_reg;
        raw_rate_next = raw_rate_reg;
        acc_sc_next   = acc_sc_reg;
        rate_sc_next  = rate_sc_reg;
        energy_next   = energy_reg;
        old_sq_next   = old_sq_reg;
        mag_sq_next   = mag_sq_reg;
        mean_sq_next  = mean_sq_reg;
        rt_x_next     = rt_x_reg;
        rt_next       = rt_reg;
        dvs_rem_next  = dvs_rem_reg;
        dvs_q_next    = dvs_q_reg;
        dvq_rem_next  = dvq_rem_reg;
        dvq_q_next    = dvq_q_reg;
        m_acc_next    = m_acc_reg;
        m_rate_next   = m_rate_reg;
        m_mean_next   = m_mean_reg;
        m_std_next    = m_std_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        ram_we        = 1'b0;
        ram_waddr     = slot_reg;
        ram_wdata     = '0;

        case (state_reg)
            ST_CLEAR: begin
                ram_we = 1'b1;
                if (slot_reg == SLOT_LAST) begin
                    slot_next  = '0;
                    state_next = ST_IDLE;
                end else begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    raw_acc_next[0]  = s_raw_accel_x;
                    raw_acc_next[1]  = s_raw_accel_y;
                    raw_acc_next[2]  = s_raw_accel_z;
                    raw_rate_next[0] = s_raw_rate_x;
                    raw_rate_next[1] = s_raw_rate_y;
                    raw_rate_next[2] = s_raw_rate_z;
                    cnt_next         = '0;
                    state_next       = ST_ESQ;
                end
            end
            ST_ESQ: begin
                energy_next = ((cnt_reg == '0) ? '0 : energy_reg) + mul_p[WIDE_W-1:0];
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQ_CYCLES - 1)) begin
                    rt_x_next  = energy_next;
                    rt_next    = '0;
                    cnt_next   = '0;
                    state_next = ST_ROOT1;
                end
            end
            ST_ROOT1: begin
                rt_next   = rt_step;
                rt_x_next = {rt_x_reg[WIDE_W-5:0], 4'b0000};
                case (cnt_reg)
                    CNT_W'(0): acc_sc_next[0]  = mul_p[WIDE_W:16];
                    CNT_W'(1): acc_sc_next[1]  = mul_p[WIDE_W:16];
                    CNT_W'(2): acc_sc_next[2]  = mul_p[WIDE_W:16];
                    CNT_W'(3): rate_sc_next[0] = mul_p[WIDE_W:16];
                    CNT_W'(4): rate_sc_next[1] = mul_p[WIDE_W:16];
                    CNT_W'(5): rate_sc_next[2] = mul_p[WIDE_W:16];
                    CNT_W'(OLD_SQ_SLOT): old_sq_next = mul_p[WIDE_W-1:0];
                    default: ;
                endcase
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_CYCLES - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_MAGSQ;
                end
            end
            ST_MAGSQ: begin
                mag_sq_next = mul_p[WIDE_W-1:0];
                state_next  = ST_UPD;
            end
            ST_UPD: begin
                // drop the oldest entry, add the new magnitude
                sum_next   = sum_reg - SUM_W'(ram_rdata) + SUM_W'(rt_reg.root);
                sqsum_next = sqsum_reg - SQSUM_W'(old_sq_reg) + SQSUM_W'(mag_sq_reg);
                ram_we     = 1'b1;
                ram_wdata  = rt_reg.root;
                slot_next  = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                dvs_rem_next = '0;
                dvs_q_next   = WIDE_W'(sum_next);
                dvq_rem_next = REM_W'(sqsum_next[SQSUM_W-1:WIDE_W]);
                dvq_q_next   = sqsum_next[WIDE_W-1:0];
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                dvs_rem_next = dvs_rem_step;
                dvs_q_next   = dvs_q_step;
                dvq_rem_next = dvq_rem_step;
                dvq_q_next   = dvq_q_step;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_CYCLES - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_MEANSQ;
                end
            end
            ST_MEANSQ: begin
                mean_sq_next = mul_p[WIDE_W-1:0];
                state_next   = ST_VAR;
            end
            ST_VAR: begin
                rt_x_next  = variance;
                rt_next    = '0;
                cnt_next   = '0;
                state_next = ST_ROOT2;
            end
            ST_ROOT2: begin
                rt_next   = rt_step;
                rt_x_next = {rt_x_reg[WIDE_W-5:0], 4'b0000};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_CYCLES - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_acc_next   = acc_sc_reg;
                    m_rate_next  = rate_sc_reg;
                    m_mean_next  = dvs_q_reg[MAG_W-1:0];
                    m_std_next   = rt_reg.root;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            slot_reg    <= '0;
            sum_reg     <= '0;
            sqsum_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            slot_reg    <= slot_next;
            sum_reg     <= sum_next;
            sqsum_reg   <= sqsum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        raw_acc_reg  <= raw_acc_next;
        raw_rate_reg <= raw_rate_next;
        acc_sc_reg   <= acc_sc_next;
        rate_sc_reg  <= rate_sc_next;
        energy_reg   <= energy_next;
        old_sq_reg   <= old_sq_next;
        mag_sq_reg   <= mag_sq_next;
        mean_sq_reg  <= mean_sq_next;
        rt_x_reg     <= rt_x_next;
        rt_reg       <= rt_next;
        dvs_rem_reg  <= dvs_rem_next;
        dvs_q_reg    <= dvs_q_next;
        dvq_rem_reg  <= dvq_rem_next;
        dvq_q_reg    <= dvq_q_next;
        m_acc_reg    <= m_acc_next;
        m_rate_reg   <= m_rate_next;
        m_mean_reg   <= m_mean_next;
        m_std_reg    <= m_std_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_accel_x_out = m_acc_reg[0];
    assign m_accel_y_out = m_acc_reg[1];
    assign m_accel_z_out = m_acc_reg[2];
    assign m_rate_x_out  = m_rate_reg[0];
    assign m_rate_y_out  = m_rate_reg[1];
    assign m_rate_z_out  = m_rate_reg[2];
    assign m_window_mean = m_mean_reg;
    assign m_window_std  = m_std_reg;

endmodule

// ----- design/isws_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module isws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        // hold read data until the next read
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- tb/imu_scale_and_window_stats_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for imu_scale_and_window_stats_core: directed table then random samples,
// each result compared with a typed value or a local model of the scaling and the 64-entry window.
// Depends on isws_pkg and the core with its ring memory.
module imu_scale_and_window_stats_core_tb;

    localparam int     WIN          = 64;
    localparam longint ACCEL_GAIN   = 80336;
    localparam longint RATE_GAIN    = 128072;
    localparam int     RANDOM_ITEMS = 1400;
    localparam int     IDLE_PCT     = 14;
    localparam int     STALL_LIMIT  = 2000;
    localparam int     DRAIN_CYCLES = 60;

    typedef struct {
        logic signed [isws_pkg::RAW_W-1:0] ax, ay, az, gx, gy, gz;
    } raw_sample_t;

    typedef struct {
        logic signed [isws_pkg::SCALE_W-1:0] ax, ay, az, gx, gy, gz;
        logic        [isws_pkg::MAG_W-1:0]   mean, sdev;
    } imu_result_t;

    typedef struct {
        raw_sample_t smp;
        bit          typed;
        imu_result_t res;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [isws_pkg::RAW_W-1:0] s_raw_accel_x = '0, s_raw_accel_y = '0, s_raw_accel_z = '0;
    logic signed [isws_pkg::RAW_W-1:0] s_raw_rate_x = '0, s_raw_rate_y = '0, s_raw_rate_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [isws_pkg::SCALE_W-1:0] m_accel_x_out, m_accel_y_out, m_accel_z_out;
    logic signed [isws_pkg::SCALE_W-1:0] m_rate_x_out, m_rate_y_out, m_rate_z_out;
    logic        [isws_pkg::MAG_W-1:0]   m_window_mean, m_window_std;

    // local copy of the window state
    logic [15:0]         mag_ring [WIN];
    int unsigned         ring_slot;
    longint unsigned     mag_sum;
    longint unsigned     mag_sq_sum;

    imu_result_t         pending_results [$];
    stim_row_t           directed_rows [$];
    bit                  no_idle = 1'b0;
    int                  errors = 0;
    int                  samples_sent = 0;
    int                  results_seen = 0;
    int                  idle_cycles = 0;

    imu_scale_and_window_stats_core #(.WINDOW_LEN(WIN)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_raw_accel_x (s_raw_accel_x),
        .s_raw_accel_y (s_raw_accel_y),
        .s_raw_accel_z (s_raw_accel_z),
        .s_raw_rate_x  (s_raw_rate_x),
        .s_raw_rate_y  (s_raw_rate_y),
        .s_raw_rate_z  (s_raw_rate_z),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_accel_x_out (m_accel_x_out),
        .m_accel_y_out (m_accel_y_out),
        .m_accel_z_out (m_accel_z_out),
        .m_rate_x_out  (m_rate_x_out),
        .m_rate_y_out  (m_rate_y_out),
        .m_rate_z_out  (m_rate_z_out),
        .m_window_mean (m_window_mean),
        .m_window_std  (m_window_std)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // floor(v * gain / 65536): arithmetic shift of the signed product
    function automatic logic signed [16:0] scale_axis(logic signed [15:0] v, longint gain);
        longint prod;
        prod = longint'(v) * gain;
        return 17'(prod >>> 16);
    endfunction

    function automatic imu_result_t predict_window_stats(raw_sample_t smp);
        imu_result_t     r;
        longint          a2;
        longint unsigned energy, mag, old, mean, msq, var_est;
        r.ax = scale_axis(smp.ax, ACCEL_GAIN);
        r.ay = scale_axis(smp.ay, ACCEL_GAIN);
        r.az = scale_axis(smp.az, ACCEL_GAIN);
        r.gx = scale_axis(smp.gx, RATE_GAIN);
        r.gy = scale_axis(smp.gy, RATE_GAIN);
        r.gz = scale_axis(smp.gz, RATE_GAIN);
        a2 = longint'(smp.ax) * smp.ax + longint'(smp.ay) * smp.ay + longint'(smp.az) * smp.az;
        energy = longint'(a2);
        mag = int_sqrt(energy) & 64'hFFFF;
        old = mag_ring[ring_slot];
        mag_sum    = mag_sum - old + mag;
        mag_sq_sum = mag_sq_sum - old * old + mag * mag;
        mag_ring[ring_slot] = 16'(mag);
        ring_slot = (ring_slot + 1 >= WIN) ? 0 : ring_slot + 1;
        mean = mag_sum / WIN;
        msq  = mag_sq_sum / WIN;
        var_est = (msq > mean * mean) ? msq - mean * mean : 0;
        r.mean = 16'(mean);
        r.sdev = 16'(int_sqrt(var_est));
        return r;
    endfunction

    task automatic add_row(int ax, int ay, int az, int gx, int gy, int gz);
        stim_row_t row;
        row.smp   = '{16'(ax), 16'(ay), 16'(az), 16'(gx), 16'(gy), 16'(gz)};
        row.typed = 1'b0;
        row.res   = '{default: '0};
        directed_rows.push_back(row);
    endtask

    task automatic add_typed_row(int ax, int ay, int az, int gx, int gy, int gz,
                                 int eax, int eay, int eaz, int egx, int egy, int egz,
                                 int emean, int esdev);
        stim_row_t row;
        row.smp   = '{16'(ax), 16'(ay), 16'(az), 16'(gx), 16'(gy), 16'(gz)};
        row.typed = 1'b1;
        row.res   = '{17'(eax), 17'(eay), 17'(eaz), 17'(egx), 17'(egy), 17'(egz),
                      16'(emean), 16'(esdev)};
        directed_rows.push_back(row);
    endtask

    // Entered just after a falling edge; returns just after the falling edge that follows
    // acceptance, so the next word can keep valid high without a glitch.
    task automatic send_sample(raw_sample_t smp, bit typed, imu_result_t typed_res);
        imu_result_t predicted;
        while (!no_idle && $urandom_range(99, 0) < IDLE_PCT) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_raw_accel_x = smp.ax;
        s_raw_accel_y = smp.ay;
        s_raw_accel_z = smp.az;
        s_raw_rate_x  = smp.gx;
        s_raw_rate_y  = smp.gy;
        s_raw_rate_z  = smp.gz;
        s_valid       = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_window_stats(smp);
        pending_results.push_back(typed ? typed_res : predicted);
        samples_sent++;
        @(negedge aclk);
    endtask

    function automatic int pick(int lo, int hi);
        return lo + int'($urandom_range(hi - lo, 0));
    endfunction

    function automatic int pick_extreme();
        int vals [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
        return vals[$urandom_range(6, 0)];
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(negedge aclk) begin
        m_ready = no_idle || ($urandom_range(99, 0) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        imu_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t ns: result word with nothing expected, mean %0d std %0d",
                         $time, m_window_mean, m_window_std);
            end else begin
                exp_r = pending_results.pop_front();
                check_field("accel_x_out", exp_r.ax, m_accel_x_out);
                check_field("accel_y_out", exp_r.ay, m_accel_y_out);
                check_field("accel_z_out", exp_r.az, m_accel_z_out);
                check_field("rate_x_out", exp_r.gx, m_rate_x_out);
                check_field("rate_y_out", exp_r.gy, m_rate_y_out);
                check_field("rate_z_out", exp_r.gz, m_rate_z_out);
                check_field("window_mean", int'(exp_r.mean), int'(m_window_mean));
                check_field("window_std", int'(exp_r.sdev), int'(m_window_std));
            end
        end
    end

    // count cycles in which neither channel moves a word
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge aclk);
        $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, pending_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        raw_sample_t smp;
        raw_sample_t prev;
        imu_result_t none;
        int          kind;
        int          sgn;
        int          g_axis;
        int          grav [3];

        none      = '{default: '0};
        prev      = '{default: '0};
        ring_slot = 0;
        mag_sum   = 0;
        mag_sq_sum = 0;
        foreach (mag_ring[i]) mag_ring[i] = '0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Zero entries from reset count toward the window, so the first words
        // give exact zeros for mean and deviation when the acceleration is zero.
        add_typed_row(0, 0, 0, 0, 0, 0,  0, 0, 0, 0, 0, 0,  0, 0);
        add_typed_row(0, 0, 0, 32767, -32768, 0,  0, 0, 0, 64034, -64036, 0,  0, 0);
        // negative rates round toward minus infinity
        add_typed_row(0, 0, 0, -1, 1, 2,  0, 0, 0, -2, 1, 3,  0, 0);
        add_typed_row(0, 0, 0, -32767, 32766, -2,  0, 0, 0, -64035, 64032, -4,  0, 0);
        add_row(32767, 0, 0, 0, 0, 0);
        add_row(-32768, 0, 0, 0, 0, 0);
        add_row(-32768, -32768, -32768, 0, 0, 0);
        add_row(32767, 32767, 32767, 32767, 32767, 32767);
        add_row(-32768, -32768, -32768, -32768, -32768, -32768);
        add_row(-1, -1, -1, -1, -1, -1);
        add_row(1, 0, 0, 1, 0, 0);
        add_row(-2, -3, -5, -7, -11, -13);
        add_row(0, 0, 8192, 0, 0, 0);
        add_row(0, -8192, 0, 66, -66, 0);
        add_row('h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA);
        add_row('hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555);
        add_row(32767, -32768, 1, -1, 32767, -32768);
        add_row(100, -100, 8000, 1000, -1000, 500);

        foreach (directed_rows[i])
            send_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].res);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            no_idle = (i >= 500 && i < 750);
            kind = $urandom_range(99, 0);
            if (kind < 45) begin
                // sensor near rest: gravity on one axis plus motion noise
                g_axis = $urandom_range(2, 0);
                sgn = ($urandom_range(1, 0) != 0) ? 1 : -1;
                foreach (grav[k]) grav[k] = pick(-1500, 1500);
                grav[g_axis] = sgn * 8192 + pick(-600, 600);
                smp = '{16'(grav[0]), 16'(grav[1]), 16'(grav[2]),
                        16'(pick(-6000, 6000)), 16'(pick(-6000, 6000)), 16'(pick(-6000, 6000))};
            end else if (kind < 70) begin
                smp = '{16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 16'($urandom)};
            end else if (kind < 82) begin
                smp = '{16'(pick(-8, 8)), 16'(pick(-8, 8)), 16'(pick(-8, 8)),
                        16'(pick(-8, 8)), 16'(pick(-8, 8)), 16'(pick(-8, 8))};
            end else if (kind < 92) begin
                smp = '{16'(pick_extreme()), 16'(pick_extreme()), 16'(pick_extreme()),
                        16'(pick_extreme()), 16'(pick_extreme()), 16'(pick_extreme())};
            end else begin
                // repeat the last sample so the window settles toward zero spread
                smp = prev;
            end
            prev = smp;
            send_sample(smp, 1'b0, none);
        end
        no_idle = 1'b0;
        s_valid = 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d samples (%0d from the table), checked %0d result words;",
                 samples_sent, directed_rows.size(), results_seen);
        $display("the %0d-entry window wrapped about %0d times under random stalls on both sides.",
                 WIN, samples_sent / WIN);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- imu_scale_and_window_stats_core.f -----
design/isws_pkg.sv
design/isws_ram.sv
design/imu_scale_and_window_stats_core.sv
tb/imu_scale_and_window_stats_core_tb.sv
